FILE: src/aabb_collision_pair_tracker_defines.svh
// Assertion macros shared by the collision pair tracker modules.
// Each use expands to one labeled concurrent assertion on the rising edge of clk.
`ifndef AABB_COLLISION_PAIR_TRACKER_DEFINES_SVH
`define AABB_COLLISION_PAIR_TRACKER_DEFINES_SVH

// Checked only while the block is out of reset.
`define ACPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ACPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/acpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acpt_pkg: shared types and constants of the collision pair tracker
// Field widths, command, event and pair state codes, the control and
// status bundles between controller and datapath, and the pair state step.
// ---------------------------------------------------------------------------
package acpt_pkg;

  localparam int ID_W     = 6;
  localparam int CENTER_W = 24;
  localparam int HALF_W   = 23;
  localparam int EVENT_W  = 2;
  localparam int PSTATE_W = 2;

  localparam int DEF_NUM_COLLIDERS = 64;
  localparam int DEF_COORD_WIDTH   = 24;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_ENTER = 2'd1;
  localparam logic [EVENT_W-1:0] EV_STAY  = 2'd2;
  localparam logic [EVENT_W-1:0] EV_EXIT  = 2'd3;

  localparam logic [PSTATE_W-1:0] PS_NONE      = 2'd0;
  localparam logic [PSTATE_W-1:0] PS_ENTER     = 2'd1;
  localparam logic [PSTATE_W-1:0] PS_COLLIDING = 2'd2;
  localparam logic [PSTATE_W-1:0] PS_EXIT      = 2'd3;

  typedef struct packed {
    logic in_ready;  // take the next input transaction
    logic calc;      // evaluate the captured pair and load the result
    logic clr_we;    // clear one pair state entry
  } dp_cmd_t;

  typedef struct packed {
    logic in_accept; // an input transaction completes this cycle
    logic check_ok;  // it is a check of two distinct, in-range colliders
    logic clr_done;  // the clearing sweep is at its last entry
    logic out_full;  // the result register cannot take a new result
  } dp_sts_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  ev;
    logic [PSTATE_W-1:0] next;
  } pair_step_t;

  function automatic pair_step_t pair_step(input logic hit, input logic [PSTATE_W-1:0] prev);
    pair_step_t r;
    if (hit) begin
      if (prev == PS_NONE || prev == PS_EXIT) begin
        r.ev   = EV_ENTER;
        r.next = PS_ENTER;
      end else begin
        r.ev   = EV_STAY;
        r.next = PS_COLLIDING;
      end
    end else begin
      if (prev == PS_ENTER || prev == PS_COLLIDING) begin
        r.ev   = EV_EXIT;
        r.next = PS_EXIT;
      end else begin
        r.ev   = EV_NONE;
        r.next = PS_NONE;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/acpt_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acpt_in_if: command channel of the collision pair tracker
// Valid/ready channel carrying box writes and pair checks.
// ---------------------------------------------------------------------------
interface acpt_in_if import acpt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic        [ID_W-1:0]     first_id;
  logic        [ID_W-1:0]     second_id;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic signed [CENTER_W-1:0] center_z;
  logic        [HALF_W-1:0]   half_x;
  logic        [HALF_W-1:0]   half_y;
  logic        [HALF_W-1:0]   half_z;

  modport source (
    output valid, command, first_id, second_id,
    output center_x, center_y, center_z, half_x, half_y, half_z,
    input  ready
  );

  modport sink (
    input  valid, command, first_id, second_id,
    input  center_x, center_y, center_z, half_x, half_y, half_z,
    output ready
  );
endinterface

FILE: src/acpt_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acpt_out_if: result channel of the collision pair tracker
// Valid/ready channel carrying one event per evaluated pair check.
// ---------------------------------------------------------------------------
interface acpt_out_if import acpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EVENT_W-1:0]  event_res;
  logic                overlapping;
  logic [PSTATE_W-1:0] pair_state_now;

  modport source (
    output valid, event_res, overlapping, pair_state_now,
    input  ready
  );

  modport sink (
    input  valid, event_res, overlapping, pair_state_now,
    output ready
  );
endinterface

FILE: src/aabb_collision_pair_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aabb_collision_pair_tracker: 3D box collision pair tracker
// Stores one axis-aligned box per collider and tracks enter, stay and exit
// events for checked pairs of colliders.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries commands on a valid/ready handshake. A write transaction
//   stores the box of first_id and produces no result. A check transaction
//   names two colliders and produces one result on out_ch with the event,
//   the overlap flag and the new pair state. Checks that name the same
//   collider twice, and any command with an out-of-range ID, are absorbed.
//   Writes are taken every cycle while in_ch is ready. A check is accepted,
//   then evaluated from the registered box and pair state table reads once
//   the result register is free; the result is valid on out_ch in the
//   cycle after evaluation, and in_ch is ready again in that same cycle, so
//   a new check is not taken until the last one has been evaluated.
//   The result register lets a new check be accepted while the last result
//   waits; if out_ch stays stalled, evaluation waits and in_ch stays low.
//   After reset the pair state table is swept to "none", one entry per cycle,
//   over all 2^(2*ceil(log2(NUM_COLLIDERS))) entries (4096 at 64 colliders);
//   in_ch is not ready during the sweep. Box entries are undefined until
//   written.
// ---------------------------------------------------------------------------
module aabb_collision_pair_tracker import acpt_pkg::*; #(
  parameter int NUM_COLLIDERS = DEF_NUM_COLLIDERS,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  acpt_in_if.sink    in_ch,
  acpt_out_if.source out_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  acpt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  acpt_dp #(
    .NUM_COLLIDERS (NUM_COLLIDERS),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );
endmodule

FILE: src/acpt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acpt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module acpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: src/acpt_ctrl.sv
`timescale 1ns / 1ps
`include "aabb_collision_pair_tracker_defines.svh"
// ---------------------------------------------------------------------------
// acpt_ctrl: sequencer of the collision pair tracker
// Runs the pair state clearing sweep after reset, then takes transactions
// and schedules the evaluation of each pair check.
// ---------------------------------------------------------------------------
module acpt_ctrl import acpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.in_ready = 1'b0;
    cmd.calc     = 1'b0;
    cmd.clr_we   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_accept && sts.check_ok) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        // Hold the pair until the previous result has left the output register.
        if (!sts.out_full) begin
          cmd.calc  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ACPT_ASSERT(a_calc_slot_free, cmd.calc |-> !sts.out_full, "evaluation with output occupied")
  `ACPT_ASSERT(a_calc_from_check,
    (state_r == ST_CALC && $past(state_r) == ST_IDLE) |-> $past(sts.in_accept && sts.check_ok),
    "evaluation started without an accepted check")
  `ACPT_ASSERT(a_clear_complete,
    ($past(state_r) == ST_CLEAR && state_r != ST_CLEAR) |-> $past(sts.clr_done),
    "clearing sweep left early")
endmodule

FILE: src/acpt_dp.sv
`timescale 1ns / 1ps
`include "aabb_collision_pair_tracker_defines.svh"
// ---------------------------------------------------------------------------
// acpt_dp: datapath of the collision pair tracker
// Box table, pair state table, overlap test and the result register.
// ---------------------------------------------------------------------------
module acpt_dp import acpt_pkg::*; #(
  parameter int NUM_COLLIDERS = DEF_NUM_COLLIDERS,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  acpt_in_if.sink           in_ch,
  acpt_out_if.source        out_ch,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts
);
  localparam int CW      = COORD_WIDTH;
  localparam int AW      = $clog2(NUM_COLLIDERS);
  localparam int PAIR_AW = 2 * AW;
  localparam int PAIR_D  = 1 << PAIR_AW;
  localparam int CEXT_W  = (CW > CENTER_W) ? CW : CENTER_W;
  localparam int HEXT_W  = (CW - 1 > HALF_W) ? CW - 1 : HALF_W;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic        [CW-2:0] hx;
    logic        [CW-2:0] hy;
    logic        [CW-2:0] hz;
  } box_t;

  // Inclusive interval test; bounds are one bit wider than the coordinates.
  function automatic logic axis_hit(input logic signed [CW-1:0] ca, input logic [CW-2:0] ha,
                                    input logic signed [CW-1:0] cb, input logic [CW-2:0] hb);
    logic signed [CW:0] amin, amax, bmin, bmax;
    amin = {ca[CW-1], ca} - {2'b00, ha};
    amax = {ca[CW-1], ca} + {2'b00, ha};
    bmin = {cb[CW-1], cb} - {2'b00, hb};
    bmax = {cb[CW-1], cb} + {2'b00, hb};
    return (amin <= bmax) && (bmin <= amax);
  endfunction

  logic [AW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [PAIR_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0]  event_r, event_nxt;
  logic                ovl_r, ovl_nxt;
  logic [PSTATE_W-1:0] st_r, st_nxt;

  logic                in_accept, first_ok, second_ok, write_ok, box_we;
  logic [AW-1:0]       lo_in, hi_in, lo_rd, hi_rd;
  logic [CEXT_W-1:0]   cx_ext, cy_ext, cz_ext;
  logic [HEXT_W-1:0]   hx_ext, hy_ext, hz_ext;
  box_t                box_wr, box_lo, box_hi;
  logic                hit;
  pair_step_t          step;
  logic                pair_we;
  logic [PAIR_AW-1:0]  pair_waddr;
  logic [PSTATE_W-1:0] pair_wdata, pair_prev;

  assign in_ch.ready = cmd.in_ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign first_ok    = int'(in_ch.first_id) < NUM_COLLIDERS;
  assign second_ok   = int'(in_ch.second_id) < NUM_COLLIDERS;
  assign write_ok    = (in_ch.command == CMD_WRITE) && first_ok;
  assign box_we      = in_accept && write_ok;

  assign sts.in_accept = in_accept;
  assign sts.check_ok  = (in_ch.command == CMD_CHECK) && first_ok && second_ok &&
                         (in_ch.first_id != in_ch.second_id);
  assign sts.clr_done  = (clr_cnt_r == {PAIR_AW{1'b1}});
  assign sts.out_full  = out_valid_r && !out_ch.ready;

  always_comb begin
    if (in_ch.first_id < in_ch.second_id) begin
      lo_in = AW'(in_ch.first_id);
      hi_in = AW'(in_ch.second_id);
    end else begin
      lo_in = AW'(in_ch.second_id);
      hi_in = AW'(in_ch.first_id);
    end
  end

  // Fields wider than the coordinate format are truncated to its low bits.
  assign cx_ext = CEXT_W'($unsigned(in_ch.center_x));
  assign cy_ext = CEXT_W'($unsigned(in_ch.center_y));
  assign cz_ext = CEXT_W'($unsigned(in_ch.center_z));
  assign hx_ext = HEXT_W'(in_ch.half_x);
  assign hy_ext = HEXT_W'(in_ch.half_y);
  assign hz_ext = HEXT_W'(in_ch.half_z);

  assign box_wr.cx = cx_ext[CW-1:0];
  assign box_wr.cy = cy_ext[CW-1:0];
  assign box_wr.cz = cz_ext[CW-1:0];
  assign box_wr.hx = hx_ext[CW-2:0];
  assign box_wr.hy = hy_ext[CW-2:0];
  assign box_wr.hz = hz_ext[CW-2:0];

  // While idle the tables are addressed straight from the channel, so the
  // read data are ready in the evaluation cycle; afterwards they hold.
  assign lo_rd = cmd.in_ready ? lo_in : lo_r;
  assign hi_rd = cmd.in_ready ? hi_in : hi_r;

  acpt_ram #(.WIDTH($bits(box_t)), .DEPTH(NUM_COLLIDERS)) u_box_lo (
    .clk   (clk),
    .we    (box_we),
    .waddr (AW'(in_ch.first_id)),
    .wdata (box_wr),
    .raddr (lo_rd),
    .rdata (box_lo)
  );

  acpt_ram #(.WIDTH($bits(box_t)), .DEPTH(NUM_COLLIDERS)) u_box_hi (
    .clk   (clk),
    .we    (box_we),
    .waddr (AW'(in_ch.first_id)),
    .wdata (box_wr),
    .raddr (hi_rd),
    .rdata (box_hi)
  );

  assign pair_we    = cmd.clr_we || cmd.calc;
  assign pair_waddr = cmd.clr_we ? clr_cnt_r : {lo_r, hi_r};
  assign pair_wdata = cmd.clr_we ? PS_NONE : step.next;

  acpt_ram #(.WIDTH(PSTATE_W), .DEPTH(PAIR_D)) u_pair (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr ({lo_rd, hi_rd}),
    .rdata (pair_prev)
  );

  assign hit = axis_hit(box_lo.cx, box_lo.hx, box_hi.cx, box_hi.hx) &&
               axis_hit(box_lo.cy, box_lo.hy, box_hi.cy, box_hi.hy) &&
               axis_hit(box_lo.cz, box_lo.hz, box_hi.cz, box_hi.hz);
  assign step = pair_step(hit, pair_prev);

  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    event_nxt     = event_r;
    ovl_nxt       = ovl_r;
    st_nxt        = st_r;
    if (in_accept) begin
      lo_nxt = lo_in;
      hi_nxt = hi_in;
    end
    if (cmd.clr_we) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
    if (cmd.calc) begin
      out_valid_nxt = 1'b1;
      event_nxt     = step.ev;
      ovl_nxt       = hit;
      st_nxt        = step.next;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    event_r <= event_nxt;
    ovl_r   <= ovl_nxt;
    st_r    <= st_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_res      = event_r;
  assign out_ch.overlapping    = ovl_r;
  assign out_ch.pair_state_now = st_r;

  `ACPT_ASSERT(a_box_write_idle, box_we |-> cmd.in_ready, "box table written outside idle")
  `ACPT_ASSERT(a_calc_loads_out, cmd.calc |=> out_valid_r, "evaluated result not presented")
  `ACPT_ASSERT(a_no_event_state,
    (out_valid_r && event_r == EV_NONE) |-> (st_r == PS_NONE && !ovl_r),
    "no-event result with a live pair state")
endmodule

FILE: sim/tb_aabb_collision_pair_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aabb_collision_pair_tracker: self-checking bench for the box pair tracker
// Drives box writes and pair checks, first from a directed table and then at
// random. The shadow box table and pair states, or the directed table, give
// each expected result, compared field by field against the result channel.
// ---------------------------------------------------------------------------
module tb_aabb_collision_pair_tracker;
  import acpt_pkg::*;

  localparam int NCOL          = DEF_NUM_COLLIDERS;
  localparam int IDLE_LIMIT    = 20000;
  localparam int ITEMS_PER_RUN = 200;
  localparam int DRAIN_CYCLES  = 10;

  localparam logic signed [CENTER_W-1:0] C_MIN = {1'b1, {(CENTER_W-1){1'b0}}};
  localparam logic signed [CENTER_W-1:0] C_MAX = {1'b0, {(CENTER_W-1){1'b1}}};
  localparam logic        [HALF_W-1:0]   H_MAX = {HALF_W{1'b1}};

  typedef struct packed {
    logic [EVENT_W-1:0]  ev;
    logic                ov;
    logic [PSTATE_W-1:0] ps;
  } pair_report_t;

  typedef struct packed {
    logic                       cmd;
    logic        [ID_W-1:0]     a;
    logic        [ID_W-1:0]     b;
    logic signed [CENTER_W-1:0] cx, cy, cz;
    logic        [HALF_W-1:0]   hx, hy, hz;
    logic                       typed;
    pair_report_t               want;
  } stim_row_t;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic rx_ready = 1'b0;

  acpt_in_if  in_ch ();
  acpt_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  aabb_collision_pair_tracker #(
    .NUM_COLLIDERS(NCOL),
    .COORD_WIDTH  (CENTER_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Shadow state of the block.
  logic signed [CENTER_W-1:0] shadow_center [NCOL][3];
  logic        [HALF_W-1:0]   shadow_half   [NCOL][3];
  logic        [PSTATE_W-1:0] pair_track    [NCOL*NCOL];
  bit                         box_written   [NCOL];
  logic        [ID_W-1:0]     written_ids   [$];

  pair_report_t pending_reports [$];
  pair_report_t head_report;

  int in_idle_pct;
  int out_stall_pct;
  int unsigned mismatches;
  int unsigned n_writes;
  int unsigned n_checks;
  int unsigned n_reports;
  int unsigned ev_seen [4];
  int unsigned idle_cycles;

  // Inclusive overlap on one axis, with bounds one bit wider than the centers.
  function automatic logic axis_hit(input logic signed [CENTER_W-1:0] ca, cb,
                                    input logic [HALF_W-1:0] ha, hb);
    logic signed [CENTER_W:0] amin, amax, bmin, bmax;
    amin = ca - $signed({1'b0, ha});
    amax = ca + $signed({1'b0, ha});
    bmin = cb - $signed({1'b0, hb});
    bmax = cb + $signed({1'b0, hb});
    return (amin <= bmax) && (bmin <= amax);
  endfunction

  // Most picks land on the first few colliders written, so pairs repeat and
  // walk through all of their states.
  function automatic logic [ID_W-1:0] pick_id();
    if (written_ids.size() > 6 && $urandom_range(0, 99) < 70)
      return written_ids[$urandom_range(0, 5)];
    return written_ids[$urandom_range(0, written_ids.size() - 1)];
  endfunction

  function automatic logic signed [CENTER_W-1:0] rand_center(input int mode);
    case (mode)
      0: return CENTER_W'(int'($urandom_range(0, 2048)) - 1024);
      1: return CENTER_W'($urandom());
      default: begin
        case ($urandom_range(0, 2))
          0: return C_MIN;
          1: return C_MAX;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] rand_half(input int mode);
    case (mode)
      0: return HALF_W'($urandom_range(0, 600));
      1: return HALF_W'($urandom());
      default: return $urandom_range(0, 1) ? H_MAX : '0;
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    int        roll;
    int        mode;
    row  = '0;
    roll = $urandom_range(0, 99);
    row.b = ID_W'($urandom());
    if (roll < 25) begin
      roll  = $urandom_range(0, 99);
      mode  = (roll < 75) ? 0 : (roll < 88) ? 1 : 2;
      row.cmd = CMD_WRITE;
      row.a   = $urandom_range(0, 1) ? pick_id() : ID_W'($urandom_range(0, NCOL - 1));
      row.cx  = rand_center(mode);
      row.cy  = rand_center(mode);
      row.cz  = rand_center(mode);
      row.hx  = rand_half(mode);
      row.hy  = rand_half(mode);
      row.hz  = rand_half(mode);
    end else begin
      // Box fields are ignored on a check, so cx and hz carry noise.
      row.cmd = CMD_CHECK;
      row.cx  = CENTER_W'($urandom());
      row.hz  = HALF_W'($urandom());
      row.a   = pick_id();
      if (roll < 30) begin
        row.b = row.a;
      end else begin
        do row.b = pick_id(); while (row.b == row.a);
      end
    end
    return row;
  endfunction

  // Presents one command, waits for the transaction and updates the shadow
  // state, queueing the expected result of a check of two distinct colliders.
  task automatic push_command(input stim_row_t row);
    logic [ID_W-1:0] lo, hi;
    logic            hit;
    logic [PSTATE_W-1:0] prev;
    pair_report_t    rep;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= row.cmd;
    in_ch.first_id  <= row.a;
    in_ch.second_id <= row.b;
    in_ch.center_x  <= row.cx;
    in_ch.center_y  <= row.cy;
    in_ch.center_z  <= row.cz;
    in_ch.half_x    <= row.hx;
    in_ch.half_y    <= row.hy;
    in_ch.half_z    <= row.hz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    if (row.cmd == CMD_WRITE) begin
      n_writes++;
      shadow_center[row.a] = '{row.cx, row.cy, row.cz};
      shadow_half[row.a]   = '{row.hx, row.hy, row.hz};
      if (!box_written[row.a]) written_ids.push_back(row.a);
      box_written[row.a] = 1'b1;
    end else begin
      n_checks++;
      if (row.a != row.b) begin
        lo  = (row.a < row.b) ? row.a : row.b;
        hi  = (row.a < row.b) ? row.b : row.a;
        hit = 1'b1;
        for (int ax = 0; ax < 3; ax++)
          hit &= axis_hit(shadow_center[lo][ax], shadow_center[hi][ax],
                          shadow_half[lo][ax], shadow_half[hi][ax]);
        prev = pair_track[lo*NCOL + hi];
        if (hit) begin
          if (prev == PS_NONE || prev == PS_EXIT) rep = '{EV_ENTER, 1'b1, PS_ENTER};
          else                                    rep = '{EV_STAY, 1'b1, PS_COLLIDING};
        end else begin
          if (prev == PS_ENTER || prev == PS_COLLIDING) rep = '{EV_EXIT, 1'b0, PS_EXIT};
          else                                          rep = '{EV_NONE, 1'b0, PS_NONE};
        end
        pair_track[lo*NCOL + hi] = rep.ps;
        pending_reports.push_back(row.typed ? row.want : rep);
      end
    end
  endtask

  // Directed table. Box 0 is a cube of half extent 256 at the origin; box 1 touches
  // it on x and y and misses it by one LSB on x and z. Boxes 62 and 63 sit at
  // the coordinate extremes with the largest half extent.
  stim_row_t directed_rows [25] = '{
    '{CMD_WRITE, 6'd0,  6'd45, 0,     0,     0,     256,   256,   256,   1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_WRITE, 6'd1,  6'd0,  512,   0,     0,     256,   256,   256,   1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd0,  6'd1,  0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_ENTER, 1'b1, PS_ENTER}},
    '{CMD_CHECK, 6'd1,  6'd0,  'h5A5A5A, 'hA5A5A5, -1, 'h2AAAAA, 'h555555, 1, 1'b1,
      '{EV_STAY, 1'b1, PS_COLLIDING}},
    '{CMD_CHECK, 6'd0,  6'd1,  0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_STAY, 1'b1, PS_COLLIDING}},
    '{CMD_WRITE, 6'd1,  6'd63, 513,   0,     0,     256,   256,   256,   1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd0,  6'd1,  0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_EXIT, 1'b0, PS_EXIT}},
    '{CMD_WRITE, 6'd1,  6'd1,  0,     -512,  0,     256,   256,   256,   1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd1,  6'd0,  0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_ENTER, 1'b1, PS_ENTER}},
    '{CMD_WRITE, 6'd1,  6'd0,  0,     0,     -513,  256,   256,   256,   1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd0,  6'd1,  0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_EXIT, 1'b0, PS_EXIT}},
    '{CMD_CHECK, 6'd0,  6'd1,  0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd1,  6'd0,  0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd0,  6'd0,  0,     0,     0,     0,     0,     0,     1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_WRITE, 6'd63, 6'd62, C_MAX, C_MAX, C_MAX, H_MAX, H_MAX, H_MAX, 1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_WRITE, 6'd62, 6'd63, C_MIN, C_MIN, C_MIN, H_MAX, H_MAX, H_MAX, 1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_WRITE, 6'd60, 6'd3,  0,     0,     0,     0,     0,     0,     1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd62, 6'd63, 0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd63, 6'd60, 0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_ENTER, 1'b1, PS_ENTER}},
    '{CMD_CHECK, 6'd60, 6'd62, 0,     0,     0,     0,     0,     0,     1'b1,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd0,  6'd63, 0,     0,     0,     0,     0,     0,     1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd62, 6'd0,  0,     0,     0,     0,     0,     0,     1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd63, 6'd63, 0,     0,     0,     0,     0,     0,     1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_WRITE, 6'd2,  6'd2,  -300,  100,   7,     20,    0,     5,     1'b0,
      '{EV_NONE, 1'b0, PS_NONE}},
    '{CMD_CHECK, 6'd2,  6'd0,  0,     0,     0,     0,     0,     0,     1'b0,
      '{EV_NONE, 1'b0, PS_NONE}}
  };

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_reports++;
      ev_seen[out_ch.event_res]++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual ev=%0d ov=%0d ps=%0d",
                 $time, out_ch.event_res, out_ch.overlapping, out_ch.pair_state_now);
      end else begin
        head_report = pending_reports.pop_front();
        if (out_ch.event_res !== head_report.ev) begin
          mismatches++;
          $display("%0t: event_res expected %0d actual %0d",
                   $time, head_report.ev, out_ch.event_res);
        end
        if (out_ch.overlapping !== head_report.ov) begin
          mismatches++;
          $display("%0t: overlapping expected %0d actual %0d",
                   $time, head_report.ov, out_ch.overlapping);
        end
        if (out_ch.pair_state_now !== head_report.ps) begin
          mismatches++;
          $display("%0t: pair_state_now expected %0d actual %0d",
                   $time, head_report.ps, out_ch.pair_state_now);
        end
      end
    end
    rx_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Watchdog: the pair state sweep after reset is the longest quiet stretch.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (pair_track[i]) pair_track[i] = PS_NONE;
    in_idle_pct     = 6;
    out_stall_pct   = 57;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_WRITE;
    in_ch.first_id  <= '0;
    in_ch.second_id <= '0;
    in_ch.center_x  <= '0;
    in_ch.center_y  <= '0;
    in_ch.center_z  <= '0;
    in_ch.half_x    <= '0;
    in_ch.half_y    <= '0;
    in_ch.half_z    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) push_command(directed_rows[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin in_idle_pct = 6;  out_stall_pct = 57; end
        1: begin in_idle_pct = 57; out_stall_pct = 6;  end
        default: begin in_idle_pct = 0; out_stall_pct = 0; end
      endcase
      repeat (ITEMS_PER_RUN) push_command(random_row());
    end
    in_ch.valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d box writes and %0d pair checks over %0d colliders.",
             n_writes, n_checks, written_ids.size());
    $display("Compared %0d results: %0d none, %0d enter, %0d stay, %0d exit.",
             n_reports, ev_seen[EV_NONE], ev_seen[EV_ENTER], ev_seen[EV_STAY],
             ev_seen[EV_EXIT]);
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
